### hw/rtl/iprk2_pkg.sv
// Package for the inertial particle RK2 step block.
// Holds grid geometry, reset values, state encoding and the controller command struct.
// No dependencies.
package iprk2_pkg;

   localparam int GRID_BITS  = 8;
   localparam int ADDR_W     = 2 * GRID_BITS;
   localparam int GRID_DEPTH = 1 << ADDR_W;
   localparam int DATA_W     = 32;
   localparam int DT_W       = 31;
   localparam int QUO_W      = 63;
   localparam int DIV_STEPS  = QUO_W;
   localparam int CNT_W      = 6;

   localparam logic [DT_W-1:0] DT_RESET = 31'd16777;
   localparam logic [40:0]     QLIM     = 41'h100_0000_0000;

   localparam logic [1:0] NB_00 = 2'd0;
   localparam logic [1:0] NB_10 = 2'd1;
   localparam logic [1:0] NB_01 = 2'd2;
   localparam logic [1:0] NB_11 = 2'd3;

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_READ  = 14'b00000000000010,
      S_MUL_A = 14'b00000000000100,
      S_SUM_A = 14'b00000000001000,
      S_MUL_B = 14'b00000000010000,
      S_SUM_B = 14'b00000000100000,
      S_MUL_U = 14'b00000001000000,
      S_SUM_U = 14'b00000010000000,
      S_MUL_P = 14'b00000100000000,
      S_MOVE  = 14'b00001000000000,
      S_MUL_D = 14'b00010000000000,
      S_DIV   = 14'b00100000000000,
      S_RELAX = 14'b01000000000000,
      S_DONE  = 14'b10000000000000
   } state_type;

   typedef struct packed {
      logic       wr_x;
      logic       wr_y;
      logic       start;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       cap_en;
      logic [1:0] cap_sel;
      logic       mul_a;
      logic       sum_a;
      logic       mul_b;
      logic       sum_b;
      logic       mul_u;
      logic       sum_u;
      logic       mul_p;
      logic       move;
      logic       mul_d;
      logic       div_init;
      logic       div_step;
      logic       relax;
      logic       stage2;
      logic       out_load;
   } dp_cmd_type;

endpackage

### hw/rtl/iprk2_req_if.sv
// Particle/grid-load request channel: valid, ready and item payload.
// Depends on nothing.
interface iprk2_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic               grid_component;
   logic [7:0]         grid_row;
   logic [7:0]         grid_col;
   logic signed [31:0] grid_value;
   logic [31:0]        pos_x;
   logic [31:0]        pos_y;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic [30:0]        relax_time;

   modport source (output valid, kind, grid_component, grid_row, grid_col, grid_value,
                   pos_x, pos_y, vel_x, vel_y, relax_time, input ready);
   modport sink   (input valid, kind, grid_component, grid_row, grid_col, grid_value,
                   pos_x, pos_y, vel_x, vel_y, relax_time, output ready);
endinterface

### hw/rtl/iprk2_rsp_if.sv
// Result channel: valid, ready and the updated particle state.
// Depends on nothing.
interface iprk2_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        new_pos_x;
   logic [31:0]        new_pos_y;
   logic signed [31:0] new_vel_x;
   logic signed [31:0] new_vel_y;
   logic               tau_zero;

   modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, tau_zero,
                   input ready);
   modport sink   (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, tau_zero,
                   output ready);
endinterface

### hw/rtl/iprk2_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module iprk2_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

### hw/rtl/iprk2_datapath.sv
// Datapath: fluid grids, interpolation, shared multiplier and iterative divider per lane.
// Depends on iprk2_pkg and iprk2_ram.
module iprk2_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  iprk2_pkg::dp_cmd_type   cmd,
   output logic                    tau_zero,
   input  logic                    csr_we,
   input  logic [30:0]             csr_wdata,
   input  logic [7:0]              grid_row,
   input  logic [7:0]              grid_col,
   input  logic signed [31:0]      grid_value,
   input  logic [31:0]             pos_x,
   input  logic [31:0]             pos_y,
   input  logic signed [31:0]      vel_x,
   input  logic signed [31:0]      vel_y,
   input  logic [30:0]             relax_time,
   output logic [31:0]             new_pos_x,
   output logic [31:0]             new_pos_y,
   output logic signed [31:0]      new_vel_x,
   output logic signed [31:0]      new_vel_y,
   output logic                    new_tau_zero
);
   import iprk2_pkg::*;

   logic [DT_W-1:0]          dt_ff;
   logic [DT_W-1:0]          tau_ff;
   logic [31:0]              p_ff    [2];
   logic [31:0]              spos_ff [2];
   logic [31:0]              n_ff    [2];
   logic signed [31:0]       v_ff    [2];
   logic signed [31:0]       h_ff    [2];
   logic signed [31:0]       w_ff    [2];
   logic signed [31:0]       a_ff    [2];
   logic signed [31:0]       b_ff    [2];
   logic signed [31:0]       u_ff    [2];
   logic signed [31:0]       nb_ff   [4][2];
   logic signed [65:0]       prod_ff [2];
   logic [31:0]              rem_ff  [2];
   logic [QUO_W-1:0]         quo_ff  [2];
   logic                     neg_ff  [2];
   logic [31:0]              opos_x_ff, opos_y_ff;
   logic signed [31:0]       ovel_x_ff, ovel_y_ff;
   logic                     otz_ff;

   logic [DATA_W-1:0]        rd [2];
   logic [ADDR_W-1:0]        rd_addr, ram_addr;
   logic [GRID_BITS-1:0]     ix, iy, ix1, iy1;
   logic [15:0]              fx, fy;
   logic [31:0]              dvs;
   logic signed [33:0]       ma [2];
   logic signed [31:0]       mb [2];
   logic signed [65:0]       prod_in [2];
   logic signed [31:0]       vsrc [2];
   logic [65:0]              mag [2];
   logic [32:0]              trial [2];
   logic [32:0]              diff [2];
   logic [40:0]              qmag [2];
   logic signed [42:0]       qs [2];
   logic signed [42:0]       vq [2];
   logic signed [31:0]       relax_res [2];

   assign tau_zero = (tau_ff == '0);
   assign ix  = spos_ff[0][31:24];
   assign iy  = spos_ff[1][31:24];
   assign ix1 = ix + 1'b1;
   assign iy1 = iy + 1'b1;
   assign fx  = spos_ff[0][23:8];
   assign fy  = spos_ff[1][23:8];
   assign dvs = cmd.stage2 ? {1'b0, tau_ff} : {tau_ff, 1'b0};

   always_comb begin
      case (cmd.rd_sel)
         NB_00:   rd_addr = {ix, iy};
         NB_10:   rd_addr = {ix1, iy};
         NB_01:   rd_addr = {ix, iy1};
         NB_11:   rd_addr = {ix1, iy1};
         default: rd_addr = {ix, iy};
      endcase
   end

   assign ram_addr = (cmd.wr_x || cmd.wr_y) ? {grid_row, grid_col} : rd_addr;

   iprk2_ram #(.WIDTH(DATA_W), .DEPTH(GRID_DEPTH)) u_grid_x (
      .clock(clock), .we(cmd.wr_x), .addr(ram_addr), .wdata(grid_value), .rdata(rd[0])
   );
   iprk2_ram #(.WIDTH(DATA_W), .DEPTH(GRID_DEPTH)) u_grid_y (
      .clock(clock), .we(cmd.wr_y), .addr(ram_addr), .wdata(grid_value), .rdata(rd[1])
   );

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         vsrc[l] = cmd.stage2 ? h_ff[l] : v_ff[l];
         ma[l] = '0;
         mb[l] = '0;
         if (cmd.mul_a) begin
            ma[l] = 34'(nb_ff[NB_10][l]) - 34'(nb_ff[NB_00][l]);
            mb[l] = {16'd0, fx};
         end else if (cmd.mul_b) begin
            ma[l] = 34'(nb_ff[NB_11][l]) - 34'(nb_ff[NB_01][l]);
            mb[l] = {16'd0, fx};
         end else if (cmd.mul_u) begin
            ma[l] = 34'(b_ff[l]) - 34'(a_ff[l]);
            mb[l] = {16'd0, fy};
         end else if (cmd.mul_p) begin
            ma[l] = 34'(vsrc[l]);
            mb[l] = {1'b0, dt_ff};
         end else if (cmd.mul_d) begin
            ma[l] = 34'(vsrc[l]) - 34'(u_ff[l]);
            mb[l] = {1'b0, dt_ff};
         end
         prod_in[l] = 66'(ma[l] * mb[l]);
         mag[l] = prod_ff[l][65] ? 66'(-prod_ff[l]) : prod_ff[l];
         trial[l] = {rem_ff[l], quo_ff[l][QUO_W-1]};
         diff[l] = trial[l] - {1'b0, dvs};
         qmag[l] = (quo_ff[l] > 63'(QLIM)) ? QLIM : quo_ff[l][40:0];
         qs[l] = neg_ff[l] ? -43'(qmag[l]) : 43'(qmag[l]);
         vq[l] = 43'(v_ff[l]) - qs[l];
         if (tau_zero) begin
            relax_res[l] = v_ff[l];
         end else if (vq[l] > 43'sd2147483647) begin
            relax_res[l] = 32'sh7fffffff;
         end else if (vq[l] < -43'sd2147483648) begin
            relax_res[l] = 32'sh80000000;
         end else begin
            relax_res[l] = vq[l][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= DT_RESET;
      end else if (csr_we) begin
         dt_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         p_ff[0]    <= pos_x;
         p_ff[1]    <= pos_y;
         spos_ff[0] <= pos_x;
         spos_ff[1] <= pos_y;
         v_ff[0]    <= vel_x;
         v_ff[1]    <= vel_y;
         tau_ff     <= relax_time;
      end
      for (int l = 0; l < 2; l++) begin
         if (cmd.cap_en) begin
            nb_ff[cmd.cap_sel][l] <= rd[l];
         end
         if (cmd.mul_a || cmd.mul_b || cmd.mul_u || cmd.mul_p || cmd.mul_d) begin
            prod_ff[l] <= prod_in[l];
         end
         if (cmd.sum_a) begin
            a_ff[l] <= nb_ff[NB_00][l] + prod_ff[l][47:16];
         end
         if (cmd.sum_b) begin
            b_ff[l] <= nb_ff[NB_01][l] + prod_ff[l][47:16];
         end
         if (cmd.sum_u) begin
            u_ff[l] <= a_ff[l] + prod_ff[l][47:16];
         end
         if (cmd.move) begin
            if (cmd.stage2) begin
               n_ff[l] <= p_ff[l] + prod_ff[l][47:16];
            end else begin
               spos_ff[l] <= p_ff[l] + prod_ff[l][48:17];
            end
         end
         if (cmd.div_init) begin
            neg_ff[l] <= prod_ff[l][65];
            quo_ff[l] <= mag[l][QUO_W-1:0];
            rem_ff[l] <= '0;
         end else if (cmd.div_step) begin
            if (!diff[l][32]) begin
               rem_ff[l] <= diff[l][31:0];
               quo_ff[l] <= {quo_ff[l][QUO_W-2:0], 1'b1};
            end else begin
               rem_ff[l] <= trial[l][31:0];
               quo_ff[l] <= {quo_ff[l][QUO_W-2:0], 1'b0};
            end
         end
         if (cmd.relax) begin
            if (cmd.stage2) begin
               w_ff[l] <= relax_res[l];
            end else begin
               h_ff[l] <= relax_res[l];
            end
         end
      end
      if (cmd.out_load) begin
         opos_x_ff <= n_ff[0];
         opos_y_ff <= n_ff[1];
         ovel_x_ff <= w_ff[0];
         ovel_y_ff <= w_ff[1];
         otz_ff    <= tau_zero;
      end
   end

   assign new_pos_x    = opos_x_ff;
   assign new_pos_y    = opos_y_ff;
   assign new_vel_x    = ovel_x_ff;
   assign new_vel_y    = ovel_y_ff;
   assign new_tau_zero = otz_ff;
endmodule

### hw/rtl/iprk2_ctrl.sv
// Controller state machine: handshakes, grid-load decode and the step sequence.
// Depends on iprk2_pkg.
module iprk2_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic                  req_component,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  tau_zero,
   output iprk2_pkg::dp_cmd_type cmd
);
   import iprk2_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             stage2_ff, stage2_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             req_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      stage2_in    = stage2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.stage2   = stage2_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (!req_kind) begin
                  cmd.wr_x = !req_component;
                  cmd.wr_y = req_component;
               end else begin
                  cmd.start = 1'b1;
                  stage2_in = 1'b0;
                  cnt_in    = '0;
                  state_in  = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.rd_en   = (cnt_ff < CNT_W'(4));
            cmd.rd_sel  = cnt_ff[1:0];
            cmd.cap_en  = (cnt_ff != '0);
            cmd.cap_sel = 2'(cnt_ff - 1'b1);
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(4)) begin
               state_in = S_MUL_A;
            end
         end
         S_MUL_A: begin
            cmd.mul_a = 1'b1;
            state_in  = S_SUM_A;
         end
         S_SUM_A: begin
            cmd.sum_a = 1'b1;
            state_in  = S_MUL_B;
         end
         S_MUL_B: begin
            cmd.mul_b = 1'b1;
            state_in  = S_SUM_B;
         end
         S_SUM_B: begin
            cmd.sum_b = 1'b1;
            state_in  = S_MUL_U;
         end
         S_MUL_U: begin
            cmd.mul_u = 1'b1;
            state_in  = S_SUM_U;
         end
         S_SUM_U: begin
            cmd.sum_u = 1'b1;
            state_in  = S_MUL_P;
         end
         S_MUL_P: begin
            cmd.mul_p = 1'b1;
            state_in  = S_MOVE;
         end
         S_MOVE: begin
            cmd.move = 1'b1;
            state_in = S_MUL_D;
         end
         S_MUL_D: begin
            cmd.mul_d = 1'b1;
            cnt_in    = '0;
            state_in  = tau_zero ? S_RELAX : S_DIV;
         end
         S_DIV: begin
            cmd.div_init = (cnt_ff == '0);
            cmd.div_step = (cnt_ff != '0);
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS)) begin
               state_in = S_RELAX;
            end
         end
         S_RELAX: begin
            cmd.relax = 1'b1;
            cnt_in    = '0;
            if (stage2_ff) begin
               state_in = S_DONE;
            end else begin
               stage2_in = 1'b1;
               state_in  = S_READ;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         stage2_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         stage2_ff    <= stage2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_div_needs_tau: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !tau_zero) else $error("divider stepped with zero tau");
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff) else $error("result load lost valid");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && !rsp_ready)) else $error("pending result overwritten");
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_x || cmd.wr_y) |-> (state_ff == S_IDLE && !cmd.rd_en))
      else $error("grid write during step");
endmodule

### hw/rtl/inertial_particle_rk2_step_top.sv
// Per stage, a particle item goes through grid reads, interpolation multiplies and adds, a
// position multiply and move, one drag multiply, a divide at one quotient bit a cycle and a
// relax step; then one output load follows. With zero tau the divide is skipped. The output
// load waits while a previous result is still pending; the next item is accepted only once the
// block is back in idle after that load. A grid load is written in the cycle it is accepted.
// Synchronous active-high reset clears control and sets time_step to 16777; grids not cleared.
module inertial_particle_rk2_step_top (
   input  logic        clock,
   input  logic        reset,
   iprk2_req_if.sink   req_chan,
   iprk2_rsp_if.source rsp_chan,
   input  logic        csr_we,
   input  logic [30:0] csr_wdata
);
   import iprk2_pkg::*;

   dp_cmd_type cmd;
   logic       tau_zero;

   iprk2_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_ready(req_chan.ready),
      .req_kind(req_chan.kind), .req_component(req_chan.grid_component),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
      .tau_zero(tau_zero), .cmd(cmd)
   );

   iprk2_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .tau_zero(tau_zero),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .grid_row(req_chan.grid_row), .grid_col(req_chan.grid_col),
      .grid_value(req_chan.grid_value),
      .pos_x(req_chan.pos_x), .pos_y(req_chan.pos_y),
      .vel_x(req_chan.vel_x), .vel_y(req_chan.vel_y),
      .relax_time(req_chan.relax_time),
      .new_pos_x(rsp_chan.new_pos_x), .new_pos_y(rsp_chan.new_pos_y),
      .new_vel_x(rsp_chan.new_vel_x), .new_vel_y(rsp_chan.new_vel_y),
      .new_tau_zero(rsp_chan.tau_zero)
   );
endmodule
